### rtl/core/mh3_pkg.sv
// Shared types, constants and a helper function for the MurmurHash3 word hash.
`timescale 1ns / 1ps

package mh3_pkg;

    // Mixing constants of MurmurHash3 x86_32.
    localparam logic [31:0] MH_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MH_C2 = 32'h1b873593;
    localparam logic [31:0] MH_N  = 32'he6546b64;
    localparam logic [31:0] MH_F1 = 32'h85ebca6b;
    localparam logic [31:0] MH_F2 = 32'hc2b2ae35;

    // Byte counts with a meaning of their own.
    localparam logic [2:0] CNT_NONE = 3'd0;
    localparam logic [2:0] CNT_FULL = 3'd4;

    // One scrambled item handed from the front end to the back end.
    typedef struct packed {
        logic [31:0] k;
        logic [2:0]  cnt;
        logic        last;
    } t_mh3_item;

    // Rotate a word left by a fixed amount.
    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        rotl32 = (x << r) | (x >> (32 - r));
    endfunction

endpackage

### rtl/core/mh3_front.sv
// Front end: accepts words, masks the tail and scrambles k in two stages.
`timescale 1ns / 1ps

module mh3_front
    import mh3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_push,
    output t_mh3_item   o_item,
    input  logic        i_full
);

    logic        r1_valid;
    logic [31:0] r1_mul;
    logic [2:0]  r1_cnt;
    logic        r1_last;
    logic        r2_valid;
    t_mh3_item   r2_item;

    logic        w_adv;
    logic        w_take;
    logic [2:0]  w_cnt;
    logic [31:0] w_mask;
    logic [31:0] w_mul1;
    logic [31:0] w_mul2;

    // The pipe moves when its last stage is empty or can enter the queue.
    assign w_adv   = !r2_valid || !i_full;
    assign o_ready = w_adv;
    assign w_take  = i_valid && w_adv;
    assign o_push  = r2_valid && !i_full;
    assign o_item  = r2_item;

    // Classify: full words count four bytes, the last word is saturated at four.
    always_comb begin
        if (!i_last_word) begin
            w_cnt = CNT_FULL;
        end else if (i_byte_count > CNT_FULL) begin
            w_cnt = CNT_FULL;
        end else begin
            w_cnt = i_byte_count;
        end
        case (w_cnt)
            3'd0:    w_mask = 32'h0000_0000;
            3'd1:    w_mask = 32'h0000_00ff;
            3'd2:    w_mask = 32'h0000_ffff;
            3'd3:    w_mask = 32'h00ff_ffff;
            default: w_mask = 32'hffff_ffff;
        endcase
    end

    // The two multiplies of the scramble, one per stage.
    assign w_mul1 = (i_data_word & w_mask) * MH_C1;
    assign w_mul2 = rotl32(r1_mul, 15) * MH_C2;

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= w_take;
            r2_valid <= r1_valid;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_mul       <= w_mul1;
            r1_cnt       <= w_cnt;
            r1_last      <= i_last_word;
            r2_item.k    <= w_mul2;
            r2_item.cnt  <= r1_cnt;
            r2_item.last <= r1_last;
        end
    end

endmodule

### rtl/core/mh3_queue.sv
// Short first-in first-out queue between the front and the back end.
`timescale 1ns / 1ps

module mh3_queue
    import mh3_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_mh3_item i_item,
    output logic      o_full,
    input  logic      i_pop,
    output t_mh3_item o_item,
    output logic      o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_mh3_item     r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/core/mh3_back.sv
// Back end: runs the hash recurrence, folds in the length and finalizes.
`timescale 1ns / 1ps

module mh3_back
    import mh3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_seed,
    input  logic        i_empty,
    input  t_mh3_item   i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_hash
);

    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_FIN1 = 2'd1;
    localparam logic [1:0] S_FIN2 = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  r_state;
    logic        r_open;
    logic [31:0] r_h;
    logic [31:0] r_len;
    logic [31:0] r_f;
    logic        r_out_valid;
    logic [31:0] r_hash;

    logic [31:0] w_base_h;
    logic [31:0] w_base_len;
    logic [31:0] w_rot;
    logic [31:0] n_h;
    logic [31:0] n_len;
    logic        w_out_free;

    assign o_pop      = (r_state == S_RUN) && !i_empty;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_valid    = r_out_valid;
    assign o_hash     = r_hash;

    // A new message starts from the seed with zero length.
    assign w_base_h   = r_open ? r_h : i_seed;
    assign w_base_len = r_open ? r_len : '0;
    assign w_rot      = rotl32(w_base_h ^ i_item.k, 13);

    // One step of the recurrence: block mix, tail xor or nothing.
    always_comb begin
        if (i_item.cnt == CNT_FULL) begin
            n_h = (w_rot << 2) + w_rot + MH_N;
        end else if (i_item.cnt != CNT_NONE) begin
            n_h = w_base_h ^ i_item.k;
        end else begin
            n_h = w_base_h;
        end
        n_len = w_base_len + {29'd0, i_item.cnt};
    end

    // Output valid: set when a hash is loaded, cleared when it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sequencer for absorbing and the three finalizer steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_open      <= 1'b0;
        end else begin
            case (r_state)
                S_RUN: begin
                    if (o_pop) begin
                        r_open <= !i_item.last;
                        if (i_item.last) begin
                            r_state <= S_FIN1;
                        end
                    end
                end
                S_FIN1: begin
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state     <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    // Accumulator, length and finalizer datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_RUN: begin
                if (o_pop) begin
                    r_h   <= n_h;
                    r_len <= n_len;
                    r_f   <= n_h ^ n_len;
                end
            end
            S_FIN1: begin
                r_f <= (r_f ^ (r_f >> 16)) * MH_F1;
            end
            S_FIN2: begin
                r_f <= (r_f ^ (r_f >> 13)) * MH_F2;
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_hash <= r_f ^ (r_f >> 16);
                end
            end
            default: begin
                r_f <= r_f;
            end
        endcase
    end

endmodule

### rtl/core/murmur3_word_hash.sv
// Top level of the streaming MurmurHash3 x86_32 word hash.
`timescale 1ns / 1ps
//
// A message enters on the s_axis channel as 32-bit words, first byte in
// tdata bits 7:0. tlast marks the final word, whose byte count (tdata bits
// 34:32, 0 to 4, larger values read as 4) says how many low bytes count.
// The byte count of other words is ignored. One finalized hash leaves on
// m_axis for each message, after its last word.
// The user must write the seed through i_cfg_wr_en / i_cfg_wr_data only
// while the block is idle; the block itself does not enforce this. The seed
// is loaded at the start of every message. A word is accepted every cycle
// while the queue has room; the front end scrambles k in a two-stage multiply
// pipe and the back end takes one word per cycle from the queue while it is
// absorbing. After the last word the back end steps through three finalizer
// states, one per multiply of fmix32 plus the output load.
// Reset clears the seed to zero, empties the pipe and the queue and closes
// any open message. A stalled receiver holds the hash in the output register;
// the back end then waits before the next hash, and the queue fills before
// s_axis_tready drops.
module murmur3_word_hash
    import mh3_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] data_word, [34:32] byte_count, rest zero
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] hash_value
);

    logic [31:0] r_seed;
    logic        w_push;
    logic        w_full;
    logic        w_pop;
    logic        w_empty;
    t_mh3_item   w_in_item;
    t_mh3_item   w_out_item;

    // Seed register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_wr_en) begin
            r_seed <= i_cfg_wr_data;
        end
    end

    mh3_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data_word  (s_axis_tdata[31:0]),
        .i_byte_count (s_axis_tdata[34:32]),
        .i_last_word  (s_axis_tlast),
        .o_push       (w_push),
        .o_item       (w_in_item),
        .i_full       (w_full)
    );

    mh3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_out_item),
        .o_empty (w_empty)
    );

    mh3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seed  (r_seed),
        .i_empty (w_empty),
        .i_item  (w_out_item),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_hash  (m_axis_tdata)
    );

endmodule
